// ----- rtl/nfha_pkg.sv -----
// ---------------------------------------------------------------------------
// nfha_pkg
// Shared widths, command codes and helpers for the next-fit heap allocator.
// ---------------------------------------------------------------------------
package nfha_pkg;

	localparam int AW    = 34;
	localparam int REQ_W = 17;
	localparam int PTR_W = 16;
	localparam int CMD_W = 2;

	typedef logic [AW-1:0] addr_t;

	localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	localparam addr_t MIN_GROW  = addr_t'(80);
	localparam addr_t MIN_BLOCK = addr_t'(16);

	function automatic logic [31:0] tag_size(input logic [31:0] w);
		return {w[31:3], 3'b000};
	endfunction

endpackage

// ----- rtl/nfha_cmd_if.sv -----
// ---------------------------------------------------------------------------
// nfha_cmd_if
// Command channel: valid/ready with command, request size and block pointer.
// ---------------------------------------------------------------------------
interface nfha_cmd_if import nfha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [REQ_W-1:0] request_bytes;
	logic [PTR_W-1:0] block_pointer;

	modport source (output valid, output command, output request_bytes,
		output block_pointer, input ready);
	modport sink (input valid, input command, input request_bytes,
		input block_pointer, output ready);
endinterface

// ----- rtl/nfha_rsp_if.sv -----
// ---------------------------------------------------------------------------
// nfha_rsp_if
// Response channel: valid/ready with result pointer and status.
// ---------------------------------------------------------------------------
interface nfha_rsp_if import nfha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PTR_W-1:0] result_pointer;
	logic             status;

	modport source (output valid, output result_pointer, output status, input ready);
	modport sink (input valid, input result_pointer, input status, output ready);
endinterface

// ----- rtl/nfha_mem.sv -----
// ---------------------------------------------------------------------------
// nfha_mem
// Heap word store: one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module nfha_mem #(
	parameter int DEPTH = 16384,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [IW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/next_fit_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// next_fit_heap_allocator
// Boundary-tag heap allocator with next-fit search over a word memory.
// ---------------------------------------------------------------------------
// Usage: commands arrive on cmd (init, allocate, release) and each one
// produces exactly one transaction on rsp with a pointer and a status.
// The block takes one command at a time; cmd.ready is high while the
// sequencer is free, and a finished response waits in an output register,
// so the next command is taken while the receiver stalls.
// Init writes the padding word, the prologue tags and the epilogue header;
// failed or null commands go straight to the response. Allocate walks block
// headers from the rover, then places the block, splitting it when the rest
// is large enough; a miss grows the heap, if capacity allows, and coalesces.
// Release frees the block and coalesces it with its free neighbours.
// Every header and footer read goes through the single read port of the
// heap memory.
// Reset clears the break (heap not initialized) and sets the rover to 8;
// heap memory is not cleared and holds meaning only after init.
// ---------------------------------------------------------------------------
module next_fit_heap_allocator import nfha_pkg::*; #(
	parameter int HEAP_BYTES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	nfha_cmd_if.sink   cmd,
	nfha_rsp_if.source rsp
);

	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int IW         = $clog2(HEAP_WORDS);
	localparam logic [AW-3:0] HW_LIM = (AW-2)'(HEAP_WORDS);
	localparam addr_t HEAP_LIM = addr_t'(HEAP_BYTES);
	localparam int NST = 47;

	typedef enum logic [NST-1:0] {
		S_IDLE   = NST'(1) << 0,
		S_INIT   = NST'(1) << 1,
		S_ASTART = NST'(1) << 2,
		S_SRCH   = NST'(1) << 3,
		S_GCHK   = NST'(1) << 4,
		S_G0     = NST'(1) << 5,
		S_G1     = NST'(1) << 6,
		S_G2     = NST'(1) << 7,
		S_G3     = NST'(1) << 8,
		S_G4     = NST'(1) << 9,
		S_P0     = NST'(1) << 10,
		S_P1     = NST'(1) << 11,
		S_P2     = NST'(1) << 12,
		S_P3     = NST'(1) << 13,
		S_P4     = NST'(1) << 14,
		S_P5     = NST'(1) << 15,
		S_P6     = NST'(1) << 16,
		S_PN2    = NST'(1) << 17,
		S_PN3    = NST'(1) << 18,
		S_R0     = NST'(1) << 19,
		S_R1     = NST'(1) << 20,
		S_R2     = NST'(1) << 21,
		S_R3     = NST'(1) << 22,
		S_M0     = NST'(1) << 23,
		S_M1     = NST'(1) << 24,
		S_M2     = NST'(1) << 25,
		S_M3     = NST'(1) << 26,
		S_M4     = NST'(1) << 27,
		S_M5     = NST'(1) << 28,
		S_MA1    = NST'(1) << 29,
		S_MA2    = NST'(1) << 30,
		S_MA3    = NST'(1) << 31,
		S_MB0    = NST'(1) << 32,
		S_MB1    = NST'(1) << 33,
		S_MB2    = NST'(1) << 34,
		S_MB3    = NST'(1) << 35,
		S_MC0    = NST'(1) << 36,
		S_MC1    = NST'(1) << 37,
		S_MC2    = NST'(1) << 38,
		S_MC3    = NST'(1) << 39,
		S_MC4    = NST'(1) << 40,
		S_MC5    = NST'(1) << 41,
		S_MC6    = NST'(1) << 42,
		S_MC7    = NST'(1) << 43,
		S_MV0    = NST'(1) << 44,
		S_MV1    = NST'(1) << 45,
		S_DONE   = NST'(1) << 46
	} state_t;

	state_t           state_q;
	addr_t            he_q, rover_q, bp_q, pb_q, nb_q, fa_q, start_q;
	addr_t            asize_q, grow_q, csize_q;
	logic [31:0]      size_q;
	logic             phase_q, pa_q, ret_alloc_q, oor_q;
	logic [1:0]       ic_q;
	logic [PTR_W-1:0] res_q, out_ptr_q;
	logic             stat_q, out_st_q, ov_q;

	logic [31:0] mem_rdata, rdv, bs32, wd;
	addr_t       rbs, nbp, rem, diff, ra, wa, asz_in, grow_in, he_grow;
	logic [REQ_W:0] req_pad;
	logic        fit, split, we_req, mem_we;

	nfha_mem #(.DEPTH(HEAP_WORDS), .IW(IW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wa[IW+1:2]),
		.wdata (wd),
		.raddr (ra[IW+1:2]),
		.rdata (mem_rdata)
	);

	assign rdv     = oor_q ? 32'd0 : mem_rdata;
	assign bs32    = tag_size(rdv);
	assign rbs     = addr_t'(bs32);
	assign nbp     = bp_q + rbs;
	assign rem     = rbs - asize_q;
	assign diff    = csize_q - asize_q;
	assign fit     = !rdv[0] && (asize_q <= rbs);
	assign split   = (rbs >= asize_q) && (rem >= MIN_BLOCK);
	assign he_grow = he_q + grow_q;
	assign mem_we  = we_req && (wa[AW-1:2] < HW_LIM);
	assign req_pad = {1'b0, cmd.request_bytes} + (REQ_W+1)'(15);
	assign asz_in  = (cmd.request_bytes <= REQ_W'(8)) ? MIN_BLOCK
		: addr_t'({req_pad[REQ_W:3], 3'b000});
	assign grow_in = (asz_in > MIN_GROW) ? asz_in : MIN_GROW;

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = ov_q;
	assign rsp.result_pointer = out_ptr_q;
	assign rsp.status         = out_st_q;

	always_comb begin
		ra     = bp_q - addr_t'(4);
		we_req = 1'b0;
		wa     = '0;
		wd     = '0;
		case (state_q)
			S_INIT: begin
				we_req = 1'b1;
				wa     = addr_t'({ic_q, 2'b00});
				case (ic_q)
					2'd0:    wd = 32'd0;
					2'd3:    wd = 32'd1;
					default: wd = 32'd9;
				endcase
			end
			S_ASTART: ra = rover_q - addr_t'(4);
			S_SRCH:   ra = (!phase_q && rbs == '0) ? addr_t'(4) : nbp - addr_t'(4);
			S_G0: begin
				we_req = 1'b1; wa = bp_q - addr_t'(4); wd = grow_q[31:0];
			end
			S_G2: begin
				we_req = 1'b1; wa = nbp - addr_t'(8); wd = grow_q[31:0];
			end
			S_G4: begin
				we_req = 1'b1; wa = nbp - addr_t'(4); wd = 32'd1;
			end
			S_P1: begin
				we_req = 1'b1;
				wa     = bp_q - addr_t'(4);
				wd     = split ? (asize_q[31:0] | 32'd1) : (rbs[31:0] | 32'd1);
			end
			S_P3: begin
				we_req = 1'b1; wa = nbp - addr_t'(8); wd = asize_q[31:0] | 32'd1;
			end
			S_P4: begin
				we_req = 1'b1; wa = bp_q + asize_q - addr_t'(4); wd = diff[31:0];
			end
			S_P5: ra = nb_q - addr_t'(4);
			S_P6: begin
				we_req = 1'b1; wa = nb_q + rbs - addr_t'(8); wd = diff[31:0];
			end
			S_PN3: begin
				we_req = 1'b1; wa = nbp - addr_t'(8); wd = csize_q[31:0] | 32'd1;
			end
			S_R1: begin
				we_req = 1'b1; wa = bp_q - addr_t'(4); wd = bs32;
			end
			S_R3: begin
				we_req = 1'b1; wa = nbp - addr_t'(8); wd = size_q;
			end
			S_M0:  ra = bp_q - addr_t'(8);
			S_M1:  ra = bp_q - rbs - addr_t'(4);
			S_M2:  ra = pb_q + rbs - addr_t'(8);
			S_M4:  ra = nbp - addr_t'(4);
			S_MA1: begin
				we_req = 1'b1; wa = bp_q - addr_t'(4); wd = size_q;
			end
			S_MA3: begin
				we_req = 1'b1; wa = nbp - addr_t'(8); wd = size_q;
			end
			S_MB0: ra = pb_q - addr_t'(4);
			S_MB1: begin
				we_req = 1'b1; wa = nb_q - addr_t'(8); wd = size_q + bs32;
			end
			S_MB2: ra = bp_q - addr_t'(8);
			S_MB3: begin
				we_req = 1'b1; wa = bp_q - rbs - addr_t'(4); wd = size_q;
			end
			S_MC0: ra = pb_q - addr_t'(4);
			S_MC1: ra = fa_q;
			S_MC2: begin
				we_req = 1'b1; wa = pb_q - addr_t'(4); wd = size_q + bs32;
			end
			S_MC4: ra = nbp - addr_t'(4);
			S_MC5: begin
				we_req = 1'b1; wa = nb_q + rbs - addr_t'(8); wd = size_q;
			end
			S_MC6: ra = bp_q - addr_t'(8);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			he_q        <= '0;
			rover_q     <= addr_t'(8);
			ov_q        <= 1'b0;
			out_ptr_q   <= '0;
			out_st_q    <= ST_OK;
			res_q       <= '0;
			stat_q      <= ST_OK;
			bp_q        <= '0;
			pb_q        <= '0;
			nb_q        <= '0;
			fa_q        <= '0;
			start_q     <= '0;
			asize_q     <= '0;
			grow_q      <= '0;
			csize_q     <= '0;
			size_q      <= '0;
			phase_q     <= 1'b0;
			pa_q        <= 1'b0;
			ret_alloc_q <= 1'b0;
			ic_q        <= '0;
			oor_q       <= 1'b0;
		end else begin
			oor_q <= !(ra[AW-1:2] < HW_LIM);
			if (ov_q && rsp.ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						res_q   <= '0;
						stat_q  <= ST_OK;
						asize_q <= asz_in;
						grow_q  <= grow_in;
						bp_q    <= addr_t'(cmd.block_pointer);
						ic_q    <= '0;
						case (cmd.command)
							CMD_INIT: state_q <= S_INIT;
							CMD_ALLOC: begin
								if (he_q == '0 || cmd.request_bytes == '0) begin
									stat_q  <= ST_FAIL;
									state_q <= S_DONE;
								end else begin
									state_q <= S_ASTART;
								end
							end
							CMD_RELEASE: begin
								if (he_q == '0) begin
									stat_q  <= ST_FAIL;
									state_q <= S_DONE;
								end else if (cmd.block_pointer == '0) begin
									state_q <= S_DONE;
								end else begin
									ret_alloc_q <= 1'b0;
									state_q     <= S_R0;
								end
							end
							default: begin
								stat_q  <= ST_FAIL;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INIT: begin
					ic_q <= ic_q + 2'd1;
					if (ic_q == 2'd3) begin
						he_q    <= addr_t'(16);
						rover_q <= addr_t'(8);
						state_q <= S_DONE;
					end
				end
				S_ASTART: begin
					bp_q    <= rover_q;
					start_q <= rover_q;
					phase_q <= 1'b0;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (!phase_q) begin
						if (rbs == '0) begin
							if (addr_t'(8) < start_q) begin
								bp_q    <= addr_t'(8);
								phase_q <= 1'b1;
							end else begin
								rover_q <= addr_t'(8);
								state_q <= S_GCHK;
							end
						end else if (fit) begin
							rover_q <= bp_q;
							state_q <= S_P0;
						end else begin
							bp_q <= nbp;
						end
					end else begin
						if (rbs == '0) begin
							rover_q <= bp_q;
							state_q <= S_GCHK;
						end else if (fit) begin
							rover_q <= bp_q;
							state_q <= S_P0;
						end else if (nbp < start_q) begin
							bp_q <= nbp;
						end else begin
							rover_q <= nbp;
							state_q <= S_GCHK;
						end
					end
				end
				S_GCHK: begin
					if (he_grow > HEAP_LIM) begin
						stat_q  <= ST_FAIL;
						state_q <= S_DONE;
					end else begin
						bp_q    <= he_q;
						state_q <= S_G0;
					end
				end
				S_G0: state_q <= S_G1;
				S_G1: state_q <= S_G2;
				S_G2: state_q <= S_G3;
				S_G3: state_q <= S_G4;
				S_G4: begin
					he_q        <= he_grow;
					ret_alloc_q <= 1'b1;
					state_q     <= S_M0;
				end
				S_P0: state_q <= S_P1;
				S_P1: begin
					csize_q <= rbs;
					state_q <= split ? S_P2 : S_PN2;
				end
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: begin
					nb_q    <= bp_q + asize_q;
					state_q <= S_P5;
				end
				S_P5: state_q <= S_P6;
				S_P6: begin
					res_q   <= bp_q[PTR_W-1:0];
					state_q <= S_DONE;
				end
				S_PN2: state_q <= S_PN3;
				S_PN3: begin
					res_q   <= bp_q[PTR_W-1:0];
					state_q <= S_DONE;
				end
				S_R0: state_q <= S_R1;
				S_R1: begin
					size_q  <= bs32;
					state_q <= S_R2;
				end
				S_R2: state_q <= S_R3;
				S_R3: state_q <= S_M0;
				S_M0: state_q <= S_M1;
				S_M1: begin
					pb_q    <= bp_q - rbs;
					state_q <= S_M2;
				end
				S_M2: state_q <= S_M3;
				S_M3: begin
					pa_q    <= rdv[0];
					state_q <= S_M4;
				end
				S_M4: begin
					size_q  <= bs32;
					nb_q    <= nbp;
					state_q <= S_M5;
				end
				S_M5: begin
					if (pa_q && rdv[0]) begin
						state_q <= ret_alloc_q ? S_P0 : S_DONE;
					end else if (pa_q) begin
						size_q  <= size_q + bs32;
						state_q <= S_MA1;
					end else if (rdv[0]) begin
						state_q <= S_MB0;
					end else begin
						fa_q    <= nb_q + rbs - addr_t'(8);
						state_q <= S_MC0;
					end
				end
				S_MA1: state_q <= S_MA2;
				S_MA2: state_q <= S_MA3;
				S_MA3: state_q <= S_MV0;
				S_MB0: state_q <= S_MB1;
				S_MB1: begin
					size_q  <= size_q + bs32;
					state_q <= S_MB2;
				end
				S_MB2: state_q <= S_MB3;
				S_MB3: begin
					bp_q    <= bp_q - rbs;
					state_q <= S_MV0;
				end
				S_MC0: state_q <= S_MC1;
				S_MC1: begin
					size_q  <= size_q + bs32;
					state_q <= S_MC2;
				end
				S_MC2: begin
					size_q  <= size_q + bs32;
					state_q <= S_MC3;
				end
				S_MC3: state_q <= S_MC4;
				S_MC4: begin
					nb_q    <= nbp;
					state_q <= S_MC5;
				end
				S_MC5: state_q <= S_MC6;
				S_MC6: state_q <= S_MC7;
				S_MC7: begin
					bp_q    <= bp_q - rbs;
					state_q <= S_MV0;
				end
				S_MV0: state_q <= S_MV1;
				S_MV1: begin
					if (rover_q > bp_q && rover_q < nbp) begin
						rover_q <= bp_q;
					end
					state_q <= ret_alloc_q ? S_P0 : S_DONE;
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q      <= 1'b1;
						out_ptr_q <= res_q;
						out_st_q  <= stat_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_break_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		he_q[2:0] == 3'b000)
		else $error("heap break not 8-byte aligned");

	a_break_bound: assert property (@(posedge clk) disable iff (!arst_n)
		he_q <= HEAP_LIM)
		else $error("heap break beyond capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !we_req)
		else $error("heap write while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q != S_IDLE))
		else $error("accepted transaction not started");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for next_fit_heap_allocator. A directed table covers
// the uninitialized heap, zero and oversized requests, null and unaligned
// releases and unknown commands. A random mix of allocate and release of
// live blocks with occasional re-init follows. Every response transaction
// is checked against a table entry or a heap-walking predictor, with random
// stalls on both channels and one long response back-pressure window.
// ---------------------------------------------------------------------------
module tb;
	import nfha_pkg::*;

	localparam int HEAP_BYTES = 65536;
	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int N_RANDOM   = 1200;
	localparam int CYCLE_LIMIT = 30000000;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [REQ_W-1:0] req;
		logic [PTR_W-1:0] ptr;
		bit               typed;
		logic [PTR_W-1:0] exp_ptr;
		logic             exp_st;
	} row_t;

	typedef struct {
		logic [PTR_W-1:0] ptr;
		logic             st;
	} answer_t;

	logic clk;
	logic arst_n;
	nfha_cmd_if cmd ();
	nfha_rsp_if rsp ();

	next_fit_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// heap shadow
	bit [31:0] heap_mem [HEAP_WORDS];
	u64_t      brk_end = 0;
	u64_t      rover   = 8;

	answer_t        pending_answers[$];
	logic [PTR_W-1:0] live_blocks[$];
	int             errors = 0;

	function automatic bit [31:0] hw_rd(u64_t a);
		u64_t i;
		i = a >> 2;
		return (i < HEAP_WORDS) ? heap_mem[i] : 32'd0;
	endfunction

	function automatic void hw_wr(u64_t a, bit [31:0] v);
		u64_t i;
		i = a >> 2;
		if (i < HEAP_WORDS)
			heap_mem[i] = v;
	endfunction

	function automatic u64_t blk_size(u64_t a);
		return u64_t'(hw_rd(a) & ~32'd7);
	endfunction

	function automatic bit blk_used(u64_t a);
		bit [31:0] w;
		w = hw_rd(a);
		return w[0];
	endfunction

	function automatic u64_t nxt(u64_t bp);
		return bp + blk_size(bp - 4);
	endfunction

	function automatic u64_t prv(u64_t bp);
		return bp - blk_size(bp - 8);
	endfunction

	function automatic u64_t foot(u64_t bp);
		return bp + blk_size(bp - 4) - 8;
	endfunction

	function automatic u64_t coalesce(u64_t bp_in);
		u64_t bp;
		bit pa, na;
		bit [31:0] sz;
		bp = bp_in;
		pa = blk_used(foot(prv(bp)));
		na = blk_used(nxt(bp) - 4);
		sz = 32'(blk_size(bp - 4));
		if (pa && na)
			return bp;
		if (pa) begin
			sz += 32'(blk_size(nxt(bp) - 4));
			hw_wr(bp - 4, sz);
			hw_wr(foot(bp), sz);
		end else if (na) begin
			sz += 32'(blk_size(prv(bp) - 4));
			hw_wr(foot(bp), sz);
			hw_wr(prv(bp) - 4, sz);
			bp = prv(bp);
		end else begin
			sz += 32'(blk_size(prv(bp) - 4)) + 32'(blk_size(foot(nxt(bp))));
			hw_wr(prv(bp) - 4, sz);
			hw_wr(foot(nxt(bp)), sz);
			bp = prv(bp);
		end
		if (rover > bp && rover < nxt(bp))
			rover = bp;
		return bp;
	endfunction

	function automatic bit fits(u64_t bp, u64_t asize);
		return !blk_used(bp - 4) && asize <= blk_size(bp - 4);
	endfunction

	function automatic bit next_fit_search(u64_t asize);
		u64_t start, bp;
		start = rover;
		bp = rover;
		while (blk_size(bp - 4) > 0) begin
			if (fits(bp, asize)) begin
				rover = bp;
				return 1'b1;
			end
			bp = nxt(bp);
		end
		bp = 8;
		while (bp < start) begin
			if (blk_size(bp - 4) == 0)
				break;
			if (fits(bp, asize)) begin
				rover = bp;
				return 1'b1;
			end
			bp = nxt(bp);
		end
		rover = bp;
		return 1'b0;
	endfunction

	function automatic void place_blk(u64_t bp, u64_t asize);
		u64_t csize, nb;
		csize = blk_size(bp - 4);
		if (csize >= asize && csize - asize >= 16) begin
			hw_wr(bp - 4, 32'(asize) | 32'd1);
			hw_wr(foot(bp), 32'(asize) | 32'd1);
			nb = bp + asize;
			hw_wr(nb - 4, 32'(csize - asize));
			hw_wr(foot(nb), 32'(csize - asize));
		end else begin
			hw_wr(bp - 4, 32'(csize) | 32'd1);
			hw_wr(foot(bp), 32'(csize) | 32'd1);
		end
	endfunction

	function automatic answer_t heap_answer(logic [CMD_W-1:0] c, logic [REQ_W-1:0] req,
			logic [PTR_W-1:0] ptr);
		answer_t a;
		u64_t asize, grow, bp;
		bit [31:0] sz;
		a.ptr = '0;
		a.st  = ST_OK;
		case (c)
			CMD_INIT: begin
				hw_wr(0, 32'd0);
				hw_wr(4, 32'd9);
				hw_wr(8, 32'd9);
				hw_wr(12, 32'd1);
				brk_end = 16;
				rover = 8;
			end
			CMD_ALLOC: begin
				if (brk_end == 0 || req == 0) begin
					a.st = ST_FAIL;
				end else begin
					asize = (req <= 8) ? 16 : 8 * ((u64_t'(req) + 15) / 8);
					if (next_fit_search(asize)) begin
						place_blk(rover, asize);
						a.ptr = PTR_W'(rover);
					end else begin
						grow = (asize > 80) ? asize : 80;
						if (brk_end + grow > HEAP_BYTES) begin
							a.st = ST_FAIL;
						end else begin
							bp = brk_end;
							hw_wr(bp - 4, 32'(grow));
							hw_wr(foot(bp), 32'(grow));
							hw_wr(nxt(bp) - 4, 32'd1);
							brk_end += grow;
							bp = coalesce(bp);
							place_blk(bp, asize);
							a.ptr = PTR_W'(bp);
						end
					end
				end
			end
			CMD_RELEASE: begin
				if (brk_end == 0) begin
					a.st = ST_FAIL;
				end else if (ptr != 0) begin
					sz = 32'(blk_size(u64_t'(ptr) - 4));
					hw_wr(u64_t'(ptr) - 4, sz);
					hw_wr(foot(u64_t'(ptr)), sz);
					void'(coalesce(u64_t'(ptr)));
				end
			end
			default: a.st = ST_FAIL;
		endcase
		return a;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [REQ_W-1:0] pick_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return REQ_W'($urandom_range(1, 64));
		if (r < 90)
			return REQ_W'($urandom_range(65, 1024));
		if (r < 98)
			return REQ_W'($urandom_range(1025, 8000));
		return REQ_W'($urandom_range(8001, 65536));
	endfunction

	// issue one transaction, predict on acceptance
	task automatic send_cmd(logic [CMD_W-1:0] c, logic [REQ_W-1:0] req,
			logic [PTR_W-1:0] ptr, bit typed, logic [PTR_W-1:0] xp, logic xs);
		answer_t a;
		int gap;
		cmd.valid         <= 1'b1;
		cmd.command       <= c;
		cmd.request_bytes <= req;
		cmd.block_pointer <= ptr;
		do
			@(posedge clk);
		while (!cmd.ready);
		a = heap_answer(c, req, ptr);
		if (c == CMD_INIT)
			live_blocks.delete();
		if (c == CMD_RELEASE && ptr != 0) begin
			for (int k = live_blocks.size() - 1; k >= 0; k--)
				if (live_blocks[k][PTR_W-1:2] == ptr[PTR_W-1:2])
					live_blocks.delete(k);
		end
		if (c == CMD_ALLOC && a.st == ST_OK)
			live_blocks.push_back(a.ptr);
		if (typed) begin
			a.ptr = xp;
			a.st  = xs;
		end
		pending_answers.push_back(a);
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	row_t directed[] = '{
		'{CMD_ALLOC,   17'd8,     16'd0,  1, 16'd0,  ST_FAIL},
		'{CMD_RELEASE, 17'd0,     16'd16, 1, 16'd0,  ST_FAIL},
		'{CMD_UNKNOWN, 17'h1ffff, 16'hffff, 1, 16'd0, ST_FAIL},
		'{CMD_INIT,    17'd0,     16'd0,  1, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd0,     16'd0,  1, 16'd0,  ST_FAIL},
		'{CMD_ALLOC,   17'd1,     16'd0,  1, 16'd16, ST_OK},
		'{CMD_ALLOC,   17'd9,     16'd0,  1, 16'd32, ST_OK},
		'{CMD_ALLOC,   17'd24,    16'd0,  1, 16'd56, ST_OK},
		'{CMD_ALLOC,   17'd100,   16'd0,  0, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd65536, 16'd0,  1, 16'd0,  ST_FAIL},
		'{CMD_RELEASE, 17'd0,     16'd0,  1, 16'd0,  ST_OK},
		'{CMD_RELEASE, 17'd0,     16'd32, 1, 16'd0,  ST_OK},
		'{CMD_RELEASE, 17'd0,     16'd19, 1, 16'd0,  ST_OK},
		'{CMD_RELEASE, 17'd0,     16'd57, 1, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd16,    16'd0,  0, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd30000, 16'd0,  0, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd30000, 16'd0,  0, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd4,     16'd0,  0, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd65535, 16'd0,  0, 16'd0,  ST_OK},
		'{CMD_INIT,    17'd0,     16'd0,  1, 16'd0,  ST_OK},
		'{CMD_ALLOC,   17'd8,     16'd0,  1, 16'd16, ST_OK}
	};

	initial begin
		int r, idx, rel_bias;
		logic [PTR_W-1:0] p;
		arst_n            <= 1'b0;
		cmd.valid         <= 1'b0;
		cmd.command       <= CMD_INIT;
		cmd.request_bytes <= '0;
		cmd.block_pointer <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_cmd(directed[i].cmd, directed[i].req, directed[i].ptr,
				directed[i].typed, directed[i].exp_ptr, directed[i].exp_st);
		for (int n = 0; n < N_RANDOM; n++) begin
			r = $urandom_range(0, 999);
			rel_bias = (live_blocks.size() > 150) ? 750 : 450;
			if (r < 5) begin
				send_cmd(CMD_INIT, REQ_W'($urandom), PTR_W'($urandom), 0, '0, ST_OK);
			end else if (r < 15) begin
				send_cmd(CMD_UNKNOWN, REQ_W'($urandom), PTR_W'($urandom), 0, '0, ST_OK);
			end else if (r < 25) begin
				send_cmd(CMD_ALLOC, '0, PTR_W'($urandom), 0, '0, ST_OK);
			end else if (r < 40) begin
				send_cmd(CMD_RELEASE, REQ_W'($urandom), '0, 0, '0, ST_OK);
			end else if (live_blocks.size() > 0 && r < rel_bias) begin
				idx = $urandom_range(0, live_blocks.size() - 1);
				p = live_blocks[idx];
				live_blocks.delete(idx);
				if ($urandom_range(0, 4) == 0)
					p[1:0] = 2'($urandom_range(1, 3));
				send_cmd(CMD_RELEASE, REQ_W'($urandom), p, 0, '0, ST_OK);
			end else begin
				send_cmd(CMD_ALLOC, pick_request(), PTR_W'($urandom), 0, '0, ST_OK);
			end
		end
		cmd.valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	int stall_left = 0;
	int rsp_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			stall_left = 0;
		end else begin
			rsp_cycles++;
			if (rsp.valid && rsp.ready) begin
				if (pending_answers.size() == 0) begin
					$display("%0t: unexpected transaction ptr=%0d status=%0d", $time,
						rsp.result_pointer, rsp.status);
					errors++;
				end else begin
					e = pending_answers.pop_front();
					if (rsp.result_pointer !== e.ptr) begin
						$display("%0t: result_pointer expected %0d actual %0d", $time,
							e.ptr, rsp.result_pointer);
						errors++;
					end
					if (rsp.status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time,
							e.st, rsp.status);
						errors++;
					end
				end
			end
			if (rsp_cycles == 3000)
				stall_left = 400;
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if ($urandom_range(0, 3) != 0) begin
				rsp.ready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				rsp.ready <= 1'b0;
			end
		end
	end

	int cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

endmodule
